// ===== rtl/mbp_pkg.sv =====
// Shared types, codes, constants and the CRC-16 byte update for the Modbus read request poller.
package mbp_pkg;

    localparam int DEF_MAX_BLOCKS     = 16;
    localparam int JOB_QUEUE_DEPTH    = 2;
    localparam int RESULT_QUEUE_DEPTH = 2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [2:0] ST_FRAME     = 3'd0;
    localparam logic [2:0] ST_NOT_DUE   = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BAD_COUNT = 3'd3;
    localparam logic [2:0] ST_LOAD_ACK  = 3'd4;

    localparam logic [1:0] CFG_SLAVE_ADDR     = 2'd0;
    localparam logic [1:0] CFG_POLL_PERIOD_MS = 2'd1;
    localparam logic [1:0] CFG_ACTIVE_BLOCKS  = 2'd2;

    localparam logic [7:0]  SLAVE_ADDR_RST    = 8'd1;
    localparam logic [31:0] POLL_PERIOD_RST   = 32'd1000;
    localparam logic [4:0]  ACTIVE_BLOCKS_RST = 5'd0;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [15:0] MAX_REG_COUNT   = 16'd125;
    localparam logic [9:0]  US_PER_MS       = 10'd1000;
    localparam int          PERIOD_US_W     = 42;

    typedef struct packed {
        logic        command;
        logic [62:0] now_us;
        logic [3:0]  slot;
        logic [15:0] reg_start;
        logic [15:0] reg_count;
    } item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
        logic [2:0] status;
        logic [3:0] block_index;
    } result_t;

    typedef struct packed {
        logic        is_frame;
        logic [2:0]  status;
        logic [3:0]  block_index;
        logic [7:0]  slave_addr;
        logic [15:0] reg_start;
        logic [15:0] reg_count;
    } job_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'd0, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== rtl/modbus_read_request_poller.sv =====
// Top level of the Modbus RTU read-holding-registers request poller.
//
// channel   ports                                      direction  word
// input     push, full, item                           in         mbp_pkg::item_t
// result    empty, pop, result                         out        mbp_pkg::result_t
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in         2-bit index, 32-bit data
//
// The front end takes one input word per cycle while its job queue has room and no
// index wrap runs. The back end gives one result word per cycle while the result queue
// has room: a load or a frameless tick gives one word, a framed tick eight (byte counter
// and CRC register step once per byte). Lowering active_blocks below the index in use
// starts an index wrap that stalls input. Reset restores all control state; table unset.
module modbus_read_request_poller #(
    parameter int MAX_BLOCKS = mbp_pkg::DEF_MAX_BLOCKS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mbp_pkg::item_t   item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output mbp_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    mbp_pkg::job_t    job_in, job_out;
    mbp_pkg::result_t res_word;
    logic             job_push, job_full, job_pop, job_empty;
    logic             res_push, res_full;

    assign cfg_ready = 1'b1;

    mbp_front #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_push  (job_push),
        .job       (job_in),
        .job_full  (job_full)
    );

    mbp_fifo #(
        .T     (mbp_pkg::job_t),
        .DEPTH (mbp_pkg::JOB_QUEUE_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty)
    );

    mbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res_word  (res_word),
        .res_full  (res_full)
    );

    mbp_fifo #(
        .T     (mbp_pkg::result_t),
        .DEPTH (mbp_pkg::RESULT_QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// ===== rtl/mbp_fifo.sv =====
// Small register-based first-in first-out queue.
module mbp_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/mbp_front.sv =====
// Front end: configuration, block table, poll timing and classification of each input word.
module mbp_front #(
    parameter int MAX_BLOCKS = mbp_pkg::DEF_MAX_BLOCKS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbp_pkg::item_t  item,
    output logic            full,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output logic            job_push,
    output mbp_pkg::job_t   job,
    input  logic            job_full
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = mbp_pkg::PERIOD_US_W;

    logic [31:0]   blk_table [MAX_BLOCKS];

    logic [7:0]    slave_reg, slave_next;
    logic [PW-1:0] period_us_reg, period_us_next;
    logic [NW-1:0] nblk_reg, nblk_next;
    logic [IW-1:0] next_index_reg, next_index_next;
    logic [62:0]   last_poll_reg, last_poll_next;
    logic          wrap_busy_reg, wrap_busy_next;
    logic [NW-1:0] wrap_val_reg, wrap_val_next;
    logic [NW-1:0] wrap_n_reg, wrap_n_next;

    logic          accept;
    logic [31:0]   entry;
    logic [NW-1:0] inc;
    logic [62:0]   elapsed;
    logic          due, count_bad, do_frame, do_load, slot_ok;
    logic [31:0]   active_ext;

    assign full     = job_full || wrap_busy_reg;
    assign accept   = push && !full;
    assign job_push = accept;
    assign slot_ok  = (32'(item.slot) < MAX_BLOCKS);

    always_comb
    begin
        entry     = blk_table[next_index_reg];
        inc       = NW'(next_index_reg) + NW'(1);
        elapsed   = item.now_us - last_poll_reg;
        due       = (last_poll_reg == '0)
                    || ((item.now_us >= last_poll_reg) && (elapsed >= 63'(period_us_reg)));
        count_bad = (entry[15:0] == 16'd0) || (entry[15:0] > mbp_pkg::MAX_REG_COUNT);

        job             = '0;
        job.block_index = 4'(next_index_reg);
        job.slave_addr  = slave_reg;
        job.reg_start   = entry[31:16];
        job.reg_count   = entry[15:0];
        do_frame        = 1'b0;
        do_load         = 1'b0;

        priority if (item.command == mbp_pkg::CMD_LOAD)
        begin
            job.status      = mbp_pkg::ST_LOAD_ACK;
            job.block_index = item.slot;
            do_load         = 1'b1;
        end
        else if (nblk_reg == '0)
            job.status = mbp_pkg::ST_EMPTY;
        else if (!due)
            job.status = mbp_pkg::ST_NOT_DUE;
        else if (count_bad)
            job.status = mbp_pkg::ST_BAD_COUNT;
        else
        begin
            job.is_frame = 1'b1;
            job.status   = mbp_pkg::ST_FRAME;
            do_frame     = 1'b1;
        end
    end

    // state update: configuration, round-robin advance and index wrap
    always_comb
    begin
        slave_next      = slave_reg;
        period_us_next  = period_us_reg;
        nblk_next       = nblk_reg;
        next_index_next = next_index_reg;
        last_poll_next  = last_poll_reg;
        wrap_busy_next  = wrap_busy_reg;
        wrap_val_next   = wrap_val_reg;
        wrap_n_next     = wrap_n_reg;
        active_ext      = {27'd0, cfg_data[4:0]};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                mbp_pkg::CFG_SLAVE_ADDR:     slave_next = cfg_data[7:0];
                mbp_pkg::CFG_POLL_PERIOD_MS:
                    period_us_next = PW'(cfg_data) * PW'(mbp_pkg::US_PER_MS);
                mbp_pkg::CFG_ACTIVE_BLOCKS:
                    nblk_next = (active_ext > 32'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS)
                                                               : NW'(active_ext);
                default: ;
            endcase
        end

        if (wrap_busy_reg)
        begin
            if (wrap_val_reg < wrap_n_reg)
            begin
                next_index_next = IW'(wrap_val_reg);
                wrap_busy_next  = 1'b0;
            end
            else
                wrap_val_next = wrap_val_reg - wrap_n_reg;
        end

        if (accept && do_frame)
        begin
            last_poll_next = item.now_us;
            if (inc < nblk_reg)
                next_index_next = IW'(inc);
            else if (inc == nblk_reg)
                next_index_next = '0;
            else
            begin
                // stale index after active_blocks was lowered
                wrap_busy_next = 1'b1;
                wrap_val_next  = inc - nblk_reg;
                wrap_n_next    = nblk_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_reg      <= mbp_pkg::SLAVE_ADDR_RST;
            period_us_reg  <= PW'(mbp_pkg::POLL_PERIOD_RST) * PW'(mbp_pkg::US_PER_MS);
            nblk_reg       <= NW'(mbp_pkg::ACTIVE_BLOCKS_RST);
            next_index_reg <= '0;
            last_poll_reg  <= '0;
            wrap_busy_reg  <= 1'b0;
            wrap_val_reg   <= '0;
            wrap_n_reg     <= '0;
        end
        else
        begin
            slave_reg      <= slave_next;
            period_us_reg  <= period_us_next;
            nblk_reg       <= nblk_next;
            next_index_reg <= next_index_next;
            last_poll_reg  <= last_poll_next;
            wrap_busy_reg  <= wrap_busy_next;
            wrap_val_reg   <= wrap_val_next;
            wrap_n_reg     <= wrap_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && do_load && slot_ok)
            blk_table[IW'(item.slot)] <= {item.reg_start, item.reg_count};
    end

endmodule

// ===== rtl/mbp_back.sv =====
// Back end: jobs to result words, serial CRC, one frame byte per cycle when not stalled.
module mbp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mbp_pkg::job_t    job,
    input  logic             job_empty,
    output logic             job_pop,
    output logic             res_push,
    output mbp_pkg::result_t res_word,
    input  logic             res_full
);

    logic [2:0]  byte_cnt_reg, byte_cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  cur_byte;
    logic        emit;

    assign emit     = !job_empty && !res_full;
    assign res_push = emit;

    always_comb
    begin
        unique case (byte_cnt_reg)
            3'd0:    cur_byte = job.slave_addr;
            3'd1:    cur_byte = mbp_pkg::FC_READ_HOLDING;
            3'd2:    cur_byte = job.reg_start[15:8];
            3'd3:    cur_byte = job.reg_start[7:0];
            3'd4:    cur_byte = job.reg_count[15:8];
            3'd5:    cur_byte = job.reg_count[7:0];
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase

        res_word             = '0;
        res_word.status      = job.status;
        res_word.block_index = job.block_index;
        byte_cnt_next        = byte_cnt_reg;
        crc_next             = crc_reg;
        job_pop              = 1'b0;

        if (job.is_frame)
        begin
            res_word.frame_byte = cur_byte;
            res_word.last       = (byte_cnt_reg == 3'd7);
            if (emit)
            begin
                byte_cnt_next = byte_cnt_reg + 3'd1;
                job_pop       = (byte_cnt_reg == 3'd7);
                if (byte_cnt_reg < 3'd6)
                    crc_next = mbp_pkg::crc_update(
                        (byte_cnt_reg == 3'd0) ? mbp_pkg::CRC_INIT : crc_reg, cur_byte);
            end
        end
        else
        begin
            res_word.last = 1'b1;
            job_pop       = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_cnt_reg <= 3'd0;
        else
            byte_cnt_reg <= byte_cnt_next;
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
    end

endmodule
